// ----- design/hpm_pkg.sv -----
package hpm_pkg;

    // Heading arithmetic
    localparam logic [8:0] DEG_FULL = 9'd360;
    localparam logic [8:0] DEG_HALF = 9'd180;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register reset values
    localparam logic [23:0] PROP_GAIN_RST   = 24'd255591;
    localparam logic [31:0] INTEG_GAIN_RST  = 32'd129;
    localparam logic [9:0]  INTEG_LIMIT_RST = 10'd500;
    localparam logic [6:0]  SPEED_LIMIT_RST = 7'd115;
    localparam logic [7:0]  MOTOR_ADDR_RST  = 8'd128;

    // Motor driver commands
    localparam logic [7:0] CMD_M1_FWD = 8'd0;
    localparam logic [7:0] CMD_M1_REV = 8'd1;
    localparam logic [7:0] CMD_M2_FWD = 8'd4;
    localparam logic [7:0] CMD_M2_REV = 8'd5;

    // Byte position inside one 4-byte packet
    localparam logic [1:0] SLOT_ADDR = 2'd0;
    localparam logic [1:0] SLOT_CMD  = 2'd1;
    localparam logic [1:0] SLOT_SPD  = 2'd2;
    localparam logic [1:0] SLOT_CHK  = 2'd3;

    // Last byte of a run of two packets
    localparam logic [2:0] LAST_BYTE_IDX = 3'd7;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_INTEG_LIMIT = 3'd2,
        REG_SPEED_LIMIT = 3'd3,
        REG_MOTOR_ADDR  = 3'd4
    } hpm_reg_t;

    typedef struct packed {
        logic [23:0] prop_gain_q16;
        logic [31:0] integ_gain_q32;
        logic [9:0]  integ_limit;
        logic [6:0]  speed_limit;
        logic [7:0]  motor_address;
    } hpm_cfg_t;

    // One classified heading sample, ready for the drive computation
    typedef struct packed {
        logic       rev;
        logic [7:0] err;
        logic [9:0] integ;
    } hpm_cmd_t;

endpackage

// ----- design/hpm_hdg_if.sv -----
interface hpm_hdg_if;
    logic       valid;
    logic       ready;
    logic [8:0] target_deg;
    logic [8:0] measured_deg;

    modport source (output valid, output target_deg, output measured_deg, input ready);
    modport sink (input valid, input target_deg, input measured_deg, output ready);
endinterface

// ----- design/hpm_byte_if.sv -----
interface hpm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       last_byte;

    modport source (output valid, output tx_byte, output last_byte, input ready);
    modport sink (input valid, input tx_byte, input last_byte, output ready);
endinterface

// ----- design/hpm_cfg_if.sv -----
interface hpm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/hpm_cfg_regs.sv -----
module hpm_cfg_regs
    import hpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hpm_cfg_if.sink    cfg,
    output hpm_cfg_t   regs
);

    hpm_cfg_t regs_reg;
    hpm_cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // Decode the register write
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PROP_GAIN:   regs_next.prop_gain_q16  = cfg.data[23:0];
                REG_INTEG_GAIN:  regs_next.integ_gain_q32 = cfg.data;
                REG_INTEG_LIMIT: regs_next.integ_limit    = cfg.data[9:0];
                REG_SPEED_LIMIT: regs_next.speed_limit    = cfg.data[6:0];
                REG_MOTOR_ADDR:  regs_next.motor_address  = cfg.data[7:0];
                default:         regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.prop_gain_q16  <= PROP_GAIN_RST;
            regs_reg.integ_gain_q32 <= INTEG_GAIN_RST;
            regs_reg.integ_limit    <= INTEG_LIMIT_RST;
            regs_reg.speed_limit    <= SPEED_LIMIT_RST;
            regs_reg.motor_address  <= MOTOR_ADDR_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ----- design/hpm_front.sv -----
module hpm_front
    import hpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hpm_hdg_if.sink    hdg,
    input  hpm_cfg_t   regs,
    output logic       push_valid,
    input  logic       push_ready,
    output hpm_cmd_t   push_cmd
);

    logic [8:0]        tn;
    logic [8:0]        mn;
    logic signed [9:0] diff;
    logic [8:0]        mag;
    logic [7:0]        err_in;
    logic              rev_in;

    logic              a_valid_reg;
    logic [7:0]        a_err_reg;
    logic              a_rev_reg;
    logic              a_advance;

    logic [9:0]        integ_reg;
    logic [9:0]        integ_next;
    logic [10:0]       integ_sum;

    // Wrap the heading difference and pick the direction
    always_comb
    begin
        tn   = (hdg.target_deg >= DEG_FULL) ? hdg.target_deg - DEG_FULL : hdg.target_deg;
        mn   = (hdg.measured_deg >= DEG_FULL) ? hdg.measured_deg - DEG_FULL
                                              : hdg.measured_deg;
        diff = signed'({1'b0, tn}) - signed'({1'b0, mn});
        mag  = diff[9] ? 9'(-diff) : diff[8:0];
        if (mag > DEG_HALF)
        begin
            err_in = 8'(DEG_FULL - mag);
            rev_in = diff[9];
        end
        else
        begin
            err_in = mag[7:0];
            rev_in = !diff[9] && (diff != 10'sd0);
        end
    end

    // Leave the stage when queued, or drop at once on zero error
    assign a_advance  = a_valid_reg && ((a_err_reg == 8'd0) || push_ready);
    assign hdg.ready  = !a_valid_reg || a_advance;
    assign push_valid = a_valid_reg && (a_err_reg != 8'd0);

    // Accumulate and clamp the integrator
    always_comb
    begin
        integ_sum  = {1'b0, integ_reg} + {3'b000, a_err_reg};
        integ_next = (integ_sum >= {1'b0, regs.integ_limit}) ? regs.integ_limit
                                                             : integ_sum[9:0];
    end

    assign push_cmd.rev   = a_rev_reg;
    assign push_cmd.err   = a_err_reg;
    assign push_cmd.integ = integ_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            integ_reg   <= 10'd0;
        end
        else
        begin
            if (hdg.valid && hdg.ready)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_advance)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_advance)
            begin
                integ_reg <= integ_next;
            end
        end
    end

    // Hold the classified item
    always_ff @(posedge clk)
    begin
        if (hdg.valid && hdg.ready)
        begin
            a_err_reg <= err_in;
            a_rev_reg <= rev_in;
        end
    end

endmodule

// ----- design/hpm_queue.sv -----
module hpm_queue
    import hpm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  hpm_cmd_t push_cmd,
    output logic     pop_valid,
    input  logic     pop_ready,
    output hpm_cmd_t pop_cmd
);

    hpm_cmd_t            entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the item
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- design/hpm_back.sv -----
module hpm_back
    import hpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  hpm_cmd_t   pop_cmd,
    input  hpm_cfg_t   regs,
    hpm_byte_if.source pkt
);

    // Multiply stage
    logic        m_valid_reg;
    logic [31:0] m_prop_reg;
    logic [41:0] m_integ_reg;
    logic        m_rev_reg;

    // Speed stage
    logic        s_valid_reg;
    logic [6:0]  s_spd_reg;
    logic        s_rev_reg;
    logic [48:0] drive_sum;
    logic [16:0] drive_val;
    logic [6:0]  spd_next;

    // Byte serializer
    logic        o_valid_reg;
    logic [2:0]  o_cnt_reg;
    logic [6:0]  o_spd_reg;
    logic        o_rev_reg;
    logic        o_done;
    logic        o_load;
    logic        s_take;
    logic        m_take;
    logic [7:0]  cmd_byte;
    logic [7:0]  chk_sum;

    // Stage handshakes
    assign o_done    = pkt.ready && (o_cnt_reg == LAST_BYTE_IDX);
    assign o_load    = s_valid_reg && (!o_valid_reg || o_done);
    assign s_take    = !s_valid_reg || o_load;
    assign m_take    = !m_valid_reg || s_take;
    assign pop_ready = m_take;

    // Sum the terms and saturate
    always_comb
    begin
        drive_sum = {1'b0, m_prop_reg, 16'd0} + {7'd0, m_integ_reg};
        drive_val = drive_sum[48:32];
        spd_next  = (drive_val > {10'd0, regs.speed_limit}) ? regs.speed_limit
                                                            : drive_val[6:0];
    end

    // Select the byte of the run
    always_comb
    begin
        if (o_cnt_reg[2])
        begin
            cmd_byte = o_rev_reg ? CMD_M2_REV : CMD_M2_FWD;
        end
        else
        begin
            cmd_byte = o_rev_reg ? CMD_M1_REV : CMD_M1_FWD;
        end
        chk_sum = regs.motor_address + cmd_byte + {1'b0, o_spd_reg};
        unique case (o_cnt_reg[1:0])
            SLOT_ADDR: pkt.tx_byte = regs.motor_address;
            SLOT_CMD:  pkt.tx_byte = cmd_byte;
            SLOT_SPD:  pkt.tx_byte = {1'b0, o_spd_reg};
            SLOT_CHK:  pkt.tx_byte = {1'b0, chk_sum[6:0]};
            default:   pkt.tx_byte = regs.motor_address;
        endcase
    end

    assign pkt.valid     = o_valid_reg;
    assign pkt.last_byte = (o_cnt_reg == LAST_BYTE_IDX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            o_cnt_reg   <= 3'd0;
        end
        else
        begin
            if (m_take)
            begin
                m_valid_reg <= pop_valid;
            end
            if (s_take)
            begin
                s_valid_reg <= m_valid_reg;
            end
            if (o_load)
            begin
                o_valid_reg <= 1'b1;
                o_cnt_reg   <= 3'd0;
            end
            else if (o_valid_reg && pkt.ready)
            begin
                o_valid_reg <= !o_done;
                o_cnt_reg   <= o_cnt_reg + 1'b1;
            end
        end
    end

    // Advance the payloads
    always_ff @(posedge clk)
    begin
        if (m_take && pop_valid)
        begin
            m_prop_reg  <= {24'd0, pop_cmd.err} * {8'd0, regs.prop_gain_q16};
            m_integ_reg <= {32'd0, pop_cmd.integ} * {10'd0, regs.integ_gain_q32};
            m_rev_reg   <= pop_cmd.rev;
        end
        if (s_take && m_valid_reg)
        begin
            s_spd_reg <= spd_next;
            s_rev_reg <= m_rev_reg;
        end
        if (o_load)
        begin
            o_spd_reg <= s_spd_reg;
            o_rev_reg <= s_rev_reg;
        end
    end

endmodule

// ----- design/heading_pi_motor_packet_top.sv -----
// An accepted heading item passes the front stage, the command queue and the
// multiply, speed and serializer stages before the first tx_byte of its run.
// A nonzero-error item yields 8 bytes, one a cycle while pkt.ready is high;
// zero-error items are dropped in the front. A 4-entry command queue lets the
// front keep accepting while bytes go out. Reset clears the integrator, empties
// all stages and the queue, and loads the default gains, limits and motor address.
module heading_pi_motor_packet_top
    import hpm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    hpm_hdg_if.sink    hdg,
    hpm_cfg_if.sink    cfg,
    hpm_byte_if.source pkt
);

    hpm_cfg_t regs;
    logic     push_valid;
    logic     push_ready;
    hpm_cmd_t push_cmd;
    logic     pop_valid;
    logic     pop_ready;
    hpm_cmd_t pop_cmd;

    hpm_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    hpm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .hdg        (hdg),
        .regs       (regs),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    hpm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    hpm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .regs      (regs),
        .pkt       (pkt)
    );

    // Only nonzero errors reach the queue
    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (push_cmd.err != 8'd0))
        else $error("zero-error item offered to command queue");

    // Integrator never exceeds its clamp when queued
    assert property (@(posedge clk) disable iff (!rst_n)
        push_valid |-> (push_cmd.integ <= regs.integ_limit))
        else $error("integrator above clamp");

    // The closing checksum byte is seven bits wide
    assert property (@(posedge clk) disable iff (!rst_n)
        (pkt.valid && pkt.last_byte) |-> (pkt.tx_byte[7] == 1'b0))
        else $error("checksum byte has top bit set");

    // Error never exceeds half a turn
    assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid |-> (pop_cmd.err <= DEG_HALF[7:0]))
        else $error("queued error above half turn");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import hpm_pkg::*;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } motor_byte_t;

    logic clk = 1'b0;
    logic rst_n;

    hpm_hdg_if  hdg();
    hpm_cfg_if  cfg();
    hpm_byte_if pkt();

    heading_pi_motor_packet_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .hdg   (hdg),
        .cfg   (cfg),
        .pkt   (pkt)
    );

    // Shadow of the controller: register copies and the integrator
    logic [23:0] kp_q16;
    logic [31:0] ki_q32;
    logic [9:0]  integ_lim;
    logic [6:0]  spd_lim;
    logic [7:0]  motor_addr;
    int unsigned integ_acc;

    motor_byte_t expected_bytes[$];

    int mismatch_count = 0;
    int bytes_seen = 0;
    int send_idle_pct = 14;
    int recv_stall_pct = 64;
    int hold_len = 0;
    int hold_seq = 0;

    // Free-running clock, 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Give up on a hung run
    initial
    begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("ERROR at %0t: byte %0d: %s", $time, bytes_seen, msg);
    endtask

    // Work out the two motor packets that one nonzero-error heading sample produces
    function automatic void predict_motor_run(input logic [8:0] tgt, input logic [8:0] meas);
        int          tn;
        int          mn;
        int          diff;
        int unsigned mag;
        int unsigned err;
        logic        rev;
        logic [63:0] drive_acc;
        logic [63:0] drive_whole;
        logic [7:0]  spd;
        logic [7:0]  cmd;
        logic [7:0]  chk;
        motor_byte_t b;

        tn = int'(tgt);
        mn = int'(meas);
        if (tn >= int'(DEG_FULL))
            tn -= int'(DEG_FULL);
        if (mn >= int'(DEG_FULL))
            mn -= int'(DEG_FULL);
        diff = tn - mn;
        mag = (diff < 0) ? -diff : diff;
        if (mag > DEG_HALF)
        begin
            err = DEG_FULL - mag;
            rev = (diff < 0);
        end
        else
        begin
            err = mag;
            rev = (diff > 0);
        end

        // Integrate, clamped at the limit even for zero error
        integ_acc = integ_acc + err;
        if (integ_acc >= integ_lim)
            integ_acc = integ_lim;

        if (err == 0)
            return;

        drive_acc = (64'(err) * 64'(kp_q16)) << 16;
        drive_acc = drive_acc + 64'(integ_acc) * 64'(ki_q32);
        drive_whole = drive_acc >> 32;
        spd = (drive_whole > 64'(spd_lim)) ? {1'b0, spd_lim} : drive_whole[7:0];

        for (int i = 0; i < 8; i++)
        begin
            if (i < 4)
                cmd = rev ? CMD_M1_REV : CMD_M1_FWD;
            else
                cmd = rev ? CMD_M2_REV : CMD_M2_FWD;
            chk = (motor_addr + cmd + spd) & 8'h7F;
            case (2'(i % 4))
                SLOT_ADDR: b.tx_byte = motor_addr;
                SLOT_CMD:  b.tx_byte = cmd;
                SLOT_SPD:  b.tx_byte = spd;
                SLOT_CHK:  b.tx_byte = chk;
                default:   b.tx_byte = 8'hxx;
            endcase
            b.last_byte = (3'(i) == LAST_BYTE_IDX);
            expected_bytes.push_back(b);
        end
    endfunction

    // Offer one heading item and hold it until the block takes it
    task automatic send_heading(input logic [8:0] tgt, input logic [8:0] meas);
        while ($urandom_range(99) < send_idle_pct)
        begin
            hdg.valid <= 1'b0;
            @(posedge clk);
        end
        hdg.valid        <= 1'b1;
        hdg.target_deg   <= tgt;
        hdg.measured_deg <= meas;
        @(posedge clk);
        while (!hdg.ready)
            @(posedge clk);
        predict_motor_run(tgt, meas);
    endtask

    // Drop valid, wait for all bytes, then cover the pipeline latency
    task automatic wait_drained();
        hdg.valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(input hpm_reg_t idx, input logic [31:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        case (idx)
            REG_PROP_GAIN:   kp_q16     = val[23:0];
            REG_INTEG_GAIN:  ki_q32     = val;
            REG_INTEG_LIMIT: integ_lim  = val[9:0];
            REG_SPEED_LIMIT: spd_lim    = val[6:0];
            REG_MOTOR_ADDR:  motor_addr = val[7:0];
            default: ;
        endcase
    endtask

    // Load all five registers once the block is idle
    task automatic set_config(input logic [23:0] kp, input logic [31:0] ki,
                              input logic [9:0] lim, input logic [6:0] spd,
                              input logic [7:0] addr);
        wait_drained();
        write_reg(REG_PROP_GAIN, {8'h00, kp});
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_INTEG_LIMIT, {22'h0, lim});
        write_reg(REG_SPEED_LIMIT, {25'h0, spd});
        write_reg(REG_MOTOR_ADDR, {24'h0, addr});
        cfg.valid <= 1'b0;
    endtask

    task automatic apply_random_config();
        logic [23:0] kp;
        logic [31:0] ki;

        case ($urandom_range(3))
            0:       kp = 24'($urandom_range(0, 24'hFFFFFF));
            1:       kp = 24'($urandom_range(0, 24'h3FFFF));
            default: kp = 24'($urandom_range(0, 24'h0FFFF));
        endcase
        case ($urandom_range(3))
            0:       ki = 32'h0;
            1:       ki = $urandom();
            2:       ki = $urandom_range(0, 32'h0FFFFFF);
            default: ki = $urandom_range(0, 32'h1FFFFFF);
        endcase
        set_config(kp, ki, 10'($urandom_range(0, 1023)), 7'($urandom_range(0, 127)),
                   8'($urandom_range(128, 135)));
    endtask

    // Mostly plain headings, with boundary differences and out-of-range values mixed in
    task automatic pick_heading_pair(output logic [8:0] tgt, output logic [8:0] meas);
        int unsigned sel;
        int unsigned base;
        int unsigned offs;
        logic [8:0]  tmp;

        sel = $urandom_range(99);
        if (sel < 70)
        begin
            tgt  = 9'($urandom_range(0, 359));
            meas = 9'($urandom_range(0, 359));
        end
        else if (sel < 82)
        begin
            base = $urandom_range(0, 359);
            case ($urandom_range(5))
                0:       offs = 0;
                1:       offs = 1;
                2:       offs = 179;
                3:       offs = 180;
                4:       offs = 181;
                default: offs = 359;
            endcase
            tgt  = 9'(base);
            meas = 9'((base + offs) % 360);
        end
        else if (sel < 92)
        begin
            tgt  = 9'($urandom_range(360, 511));
            meas = 9'($urandom_range(0, 511));
        end
        else
        begin
            tgt  = 9'($urandom_range(0, 511));
            meas = 9'($urandom_range(0, 511));
        end
        if ($urandom_range(1))
        begin
            tmp  = tgt;
            tgt  = meas;
            meas = tmp;
        end
    endtask

    // Extremes of the heading fields, wrap boundaries and zero error
    task automatic test_heading_extremes();
        send_heading(9'd0, 9'd0);
        send_heading(9'd0, 9'd180);
        send_heading(9'd180, 9'd0);
        send_heading(9'd0, 9'd181);
        send_heading(9'd181, 9'd0);
        send_heading(9'd359, 9'd0);
        send_heading(9'd0, 9'd359);
        send_heading(9'd1, 9'd0);
        send_heading(9'd0, 9'd1);
        send_heading(9'd360, 9'd0);
        send_heading(9'd511, 9'd0);
        send_heading(9'd0, 9'd511);
        send_heading(9'd40, 9'd400);
        send_heading(9'd511, 9'd511);
    endtask

    // Zero and full-scale gains, speed clamp at both ends, address range
    task automatic test_gain_extremes();
        set_config(24'h0, 32'h0, INTEG_LIMIT_RST, SPEED_LIMIT_RST, 8'd135);
        send_heading(9'd90, 9'd0);
        send_heading(9'd0, 9'd1);
        set_config(24'hFFFFFF, 32'hFFFFFFFF, 10'd1023, 7'd127, 8'd128);
        send_heading(9'd1, 9'd0);
        send_heading(9'd0, 9'd180);
        set_config(PROP_GAIN_RST, INTEG_GAIN_RST, INTEG_LIMIT_RST, 7'd0, 8'd133);
        send_heading(9'd10, 9'd20);
    endtask

    // Pump the integrator to its top, then lower the limit under it
    task automatic test_integrator_clamp();
        set_config(24'h0, 32'h10000000, 10'd1023, 7'd127, 8'd131);
        repeat (6) send_heading(9'd180, 9'd0);
        set_config(24'h0, 32'h10000000, 10'd40, 7'd127, 8'd131);
        send_heading(9'd5, 9'd5);
        send_heading(9'd6, 9'd5);
        set_config(24'h0, 32'h10000000, 10'd0, 7'd127, 8'd131);
        send_heading(9'd0, 9'd90);
    endtask

    // Stall the byte side for a long stretch while items keep coming
    task automatic test_backpressure();
        int unsigned tg;

        set_config(PROP_GAIN_RST, INTEG_GAIN_RST, INTEG_LIMIT_RST, SPEED_LIMIT_RST,
                   MOTOR_ADDR_RST);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len = 300;
        hold_seq++;
        repeat (16)
        begin
            tg = $urandom_range(0, 359);
            send_heading(9'(tg), 9'((tg + $urandom_range(1, 359)) % 360));
        end
    endtask

    // Let the block run dry between two bursts
    task automatic test_drain_pause();
        logic [8:0] tg;
        logic [8:0] ms;

        send_idle_pct  = 14;
        recv_stall_pct = 14;
        repeat (6)
        begin
            pick_heading_pair(tg, ms);
            send_heading(tg, ms);
        end
        wait_drained();
        repeat (6)
        begin
            pick_heading_pair(tg, ms);
            send_heading(tg, ms);
        end
    endtask

    task automatic test_random_headings(input int n_items, input int idle_pct,
                                        input int stall_pct);
        logic [8:0] tg;
        logic [8:0] ms;

        apply_random_config();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n_items)
        begin
            pick_heading_pair(tg, ms);
            send_heading(tg, ms);
        end
    endtask

    // Byte side: random stalls, or a counted hold-off when one is requested
    initial
    begin
        int hold_seen;
        int hold_left;

        hold_seen = 0;
        hold_left = 0;
        pkt.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seq != hold_seen)
            begin
                hold_seen = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pkt.ready <= 1'b0;
            end
            else
                pkt.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted byte with the oldest predicted one
    always @(posedge clk)
    begin
        motor_byte_t want;
        if (rst_n && pkt.valid && pkt.ready)
        begin
            if (expected_bytes.size() == 0)
                note_mismatch($sformatf("unexpected byte %02h", pkt.tx_byte));
            else
            begin
                want = expected_bytes.pop_front();
                if (pkt.tx_byte !== want.tx_byte)
                    note_mismatch($sformatf("tx_byte %02h, want %02h",
                                            pkt.tx_byte, want.tx_byte));
                if (pkt.last_byte !== want.last_byte)
                    note_mismatch($sformatf("last_byte %0b, want %0b",
                                            pkt.last_byte, want.last_byte));
            end
            bytes_seen++;
        end
    end

    initial
    begin
        rst_n            <= 1'b0;
        hdg.valid        <= 1'b0;
        hdg.target_deg   <= 9'd0;
        hdg.measured_deg <= 9'd0;
        cfg.valid        <= 1'b0;
        cfg.index        <= REG_PROP_GAIN;
        cfg.data         <= 32'h0;

        kp_q16     = PROP_GAIN_RST;
        ki_q32     = INTEG_GAIN_RST;
        integ_lim  = INTEG_LIMIT_RST;
        spd_lim    = SPEED_LIMIT_RST;
        motor_addr = MOTOR_ADDR_RST;
        integ_acc  = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_heading_extremes();
        test_gain_extremes();
        test_integrator_clamp();
        test_backpressure();
        test_drain_pause();
        test_random_headings(92, 14, 64);
        test_random_headings(92, 64, 14);
        test_random_headings(92, 0, 0);

        wait_drained();
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
